// ===== hdl/isotp_receive_reassembler_assert.svh =====
// Assertion macros for the ISO-TP receive reassembler.
`ifndef ISOTP_RECEIVE_REASSEMBLER_ASSERT_SVH
`define ISOTP_RECEIVE_REASSEMBLER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define ISOTP_RR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ISOTP_RR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/isotp_rr_pkg.sv =====
// Types, codes and helpers shared by the ISO-TP receive reassembler.
package isotp_rr_pkg;

  localparam int unsigned LenW   = 12;
  localparam int unsigned SeqW   = 4;
  localparam int unsigned DataW  = 56;
  localparam int unsigned NBytes = 7;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_FIRST  = 2'd1;
  localparam logic [1:0] KIND_CONSEC = 2'd2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RECV = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  localparam logic [LenW-1:0] FIRST_BYTES = 12'd6;
  localparam logic [LenW-1:0] CONS_BYTES  = 12'd7;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_RECV = 4'b0010,
    PH_DONE = 4'b0100,
    PH_ERR  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]       frame_kind;
    logic [LenW-1:0]  message_length;
    logic [SeqW-1:0]  sequence_number;
    logic [DataW-1:0] data_bytes;
  } frame_t;

  typedef struct packed {
    logic [DataW-1:0] payload_bytes;
    logic [2:0]       payload_count;
    logic             send_flow_control;
    logic [1:0]       receive_status;
    logic             message_last;
  } result_t;

  function automatic logic [1:0] phase_status(phase_t ph);
    logic [1:0] st;
    unique case (ph)
      PH_IDLE: st = ST_IDLE;
      PH_RECV: st = ST_RECV;
      PH_DONE: st = ST_DONE;
      PH_ERR:  st = ST_ERR;
      default: st = ST_ERR;
    endcase
    return st;
  endfunction

endpackage

// ===== hdl/isotp_rr_core.sv =====
// Reassembly state and per-frame update logic.
`include "isotp_receive_reassembler_assert.svh"

module isotp_rr_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  isotp_rr_pkg::frame_t frame,
  output isotp_rr_pkg::result_t res
);
  import isotp_rr_pkg::*;

  phase_t          phase, phase_next;
  logic [SeqW-1:0] expected_sequence, expected_sequence_next;
  logic [LenW-1:0] total_length, total_length_next;
  logic [LenW-1:0] bytes_delivered, bytes_delivered_next;

  logic [SeqW-1:0] seq_inc;
  logic [LenW-1:0] left;
  logic [LenW-1:0] sum;
  logic [2:0]      count;
  logic            fc;
  logic            last;

  always_comb begin
    seq_inc = expected_sequence + 4'd1;
    left = (total_length > bytes_delivered) ? (total_length - bytes_delivered) : '0;
    sum = '0;
    count = '0;
    fc = 1'b0;
    last = 1'b0;
    phase_next = phase;
    expected_sequence_next = expected_sequence;
    total_length_next = total_length;
    bytes_delivered_next = bytes_delivered;
    priority if (frame.frame_kind == KIND_SINGLE) begin
      count = (frame.message_length > CONS_BYTES) ? 3'd7 : frame.message_length[2:0];
      total_length_next = frame.message_length;
      bytes_delivered_next = {9'd0, count};
      expected_sequence_next = '0;
      phase_next = PH_DONE;
      last = 1'b1;
    end else if (frame.frame_kind == KIND_FIRST) begin
      count = (frame.message_length > FIRST_BYTES) ? 3'd6 : frame.message_length[2:0];
      total_length_next = frame.message_length;
      bytes_delivered_next = {9'd0, count};
      expected_sequence_next = '0;
      if (frame.message_length <= FIRST_BYTES) begin
        phase_next = PH_DONE;
        last = 1'b1;
      end else begin
        phase_next = PH_RECV;
        fc = 1'b1;
      end
    end else if (frame.frame_kind == KIND_CONSEC && phase == PH_RECV) begin
      expected_sequence_next = seq_inc;
      if (frame.sequence_number != seq_inc) begin
        phase_next = PH_ERR;
      end else begin
        count = (left > CONS_BYTES) ? 3'd7 : left[2:0];
        sum = bytes_delivered + {9'd0, count};
        bytes_delivered_next = sum;
        if (sum >= total_length) begin
          phase_next = PH_DONE;
          last = 1'b1;
        end
      end
    end else begin
      phase_next = PH_ERR;
    end
  end

  always_comb begin
    for (int i = 0; i < NBytes; i++) begin
      res.payload_bytes[8*i +: 8] = (i < int'(count)) ? frame.data_bytes[8*i +: 8] : 8'd0;
    end
    res.payload_count = count;
    res.send_flow_control = fc;
    res.receive_status = phase_status(phase_next);
    res.message_last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      expected_sequence <= '0;
      total_length <= '0;
      bytes_delivered <= '0;
    end else if (step) begin
      phase <= phase_next;
      expected_sequence <= expected_sequence_next;
      total_length <= total_length_next;
      bytes_delivered <= bytes_delivered_next;
    end
  end

  `ISOTP_RR_ASSERT(a_last_done, res.message_last |-> res.receive_status == ST_DONE, "last without done")
  `ISOTP_RR_ASSERT(a_err_empty, res.receive_status == ST_ERR |-> res.payload_count == 3'd0, "payload on error")
  `ISOTP_RR_ASSERT(a_fc_recv, res.send_flow_control |-> (res.receive_status == ST_RECV && res.payload_count == 3'd6), "bad flow control")
  `ISOTP_RR_ASSERT(a_step_last, (step && res.message_last) |=> phase == PH_DONE, "done not held")
  `ISOTP_RR_ASSERT_ALWAYS(a_recv_short, phase == PH_RECV |-> bytes_delivered < total_length, "receiving past length")

endmodule

// ===== hdl/isotp_receive_reassembler.sv =====
// Top level of the ISO-TP receive reassembler: input and result registers.
// A frame is held in the input register; its result is then registered as out_res.
// Throughput: one frame per cycle when not stalled; the core state loop is registered.
// Backpressure on the result side stalls the input only when both registers are full.
// Reset: synchronous; clears both valid flags and returns the state to idle.
module isotp_receive_reassembler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  frame_kind,
  input  logic [11:0] message_length,
  input  logic [3:0]  sequence_number,
  input  logic [55:0] data_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [55:0] payload_bytes,
  output logic [2:0]  payload_count,
  output logic        send_flow_control,
  output logic [1:0]  receive_status,
  output logic        message_last
);
  import isotp_rr_pkg::*;

  logic    s1_valid;
  frame_t  s1_frame;
  logic    out_open;
  logic    advance;
  result_t res;
  result_t out_res;

  assign out_open = !out_valid || !out_stall;
  assign advance  = s1_valid && out_open;
  assign in_stall = s1_valid && !out_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_frame <= '{frame_kind, message_length, sequence_number, data_bytes};
    end
  end

  isotp_rr_core u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .frame (s1_frame),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign payload_bytes     = out_res.payload_bytes;
  assign payload_count     = out_res.payload_count;
  assign send_flow_control = out_res.send_flow_control;
  assign receive_status    = out_res.receive_status;
  assign message_last      = out_res.message_last;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the ISO-TP receive reassembler: scoreboard, stimulus and checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import isotp_rr_pkg::*;

  localparam logic [1:0] KIND_OTHER = 2'd3;
  localparam int ITEMS = 850;
  localparam int QUIET_TAIL = 120;
  localparam int IDLE_LIMIT = 1000;

  class reassembly_scoreboard;
    logic [1:0]      phase;
    logic [SeqW-1:0] last_seq;
    logic [LenW-1:0] total_len;
    logic [LenW-1:0] delivered;
    result_t         pending_payloads[$];
    int              errors;

    function new();
      phase = ST_IDLE;
      last_seq = '0;
      total_len = '0;
      delivered = '0;
      errors = 0;
    endfunction

    function int pending();
      return pending_payloads.size();
    endfunction

    function void note_frame(frame_t f);
      result_t         r;
      logic [LenW-1:0] cnt;
      logic [LenW-1:0] left;
      r = '0;
      cnt = '0;
      if (f.frame_kind == KIND_SINGLE) begin
        cnt = (f.message_length > CONS_BYTES) ? CONS_BYTES : f.message_length;
        total_len = f.message_length;
        delivered = cnt;
        last_seq = '0;
        phase = ST_DONE;
        r.message_last = 1'b1;
      end else if (f.frame_kind == KIND_FIRST) begin
        cnt = (f.message_length > FIRST_BYTES) ? FIRST_BYTES : f.message_length;
        total_len = f.message_length;
        delivered = cnt;
        last_seq = '0;
        if (cnt >= f.message_length) begin
          phase = ST_DONE;
          r.message_last = 1'b1;
        end else begin
          phase = ST_RECV;
          r.send_flow_control = 1'b1;
        end
      end else if (f.frame_kind == KIND_CONSEC && phase == ST_RECV) begin
        last_seq = last_seq + 1'b1;
        if (f.sequence_number != last_seq) begin
          phase = ST_ERR;
        end else begin
          left = (total_len > delivered) ? total_len - delivered : '0;
          cnt = (left > CONS_BYTES) ? CONS_BYTES : left;
          delivered = delivered + cnt;
          if (delivered >= total_len) begin
            phase = ST_DONE;
            r.message_last = 1'b1;
          end
        end
      end else begin
        phase = ST_ERR;
      end
      for (int b = 0; b < NBytes; b++) begin
        if (b < cnt) r.payload_bytes[8*b +: 8] = f.data_bytes[8*b +: 8];
      end
      r.payload_count = cnt[2:0];
      r.receive_status = phase;
      pending_payloads.insert(pending_payloads.size(), r);
    endfunction

    function void compare_field(string name, logic [DataW-1:0] exp, logic [DataW-1:0] act);
      if (exp !== act) begin
        errors++;
        $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp, act);
      end
    endfunction

    function void check_result(result_t act);
      result_t exp;
      if (pending_payloads.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expected none actual %h", $time, act);
        return;
      end
      exp = pending_payloads.pop_front();
      compare_field("payload_bytes", exp.payload_bytes, act.payload_bytes);
      compare_field("payload_count", DataW'(exp.payload_count), DataW'(act.payload_count));
      compare_field("send_flow_control", DataW'(exp.send_flow_control),
                    DataW'(act.send_flow_control));
      compare_field("receive_status", DataW'(exp.receive_status),
                    DataW'(act.receive_status));
      compare_field("message_last", DataW'(exp.message_last), DataW'(act.message_last));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  frame_kind;
  logic [11:0] message_length;
  logic [3:0]  sequence_number;
  logic [55:0] data_bytes;
  logic        out_valid;
  logic        out_stall;
  logic [55:0] payload_bytes;
  logic [2:0]  payload_count;
  logic        send_flow_control;
  logic [1:0]  receive_status;
  logic        message_last;

  reassembly_scoreboard board;
  bit quiet;
  int sent;
  int idle_cycles;

  isotp_receive_reassembler dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .frame_kind(frame_kind),
    .message_length(message_length),
    .sequence_number(sequence_number),
    .data_bytes(data_bytes),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .payload_bytes(payload_bytes),
    .payload_count(payload_count),
    .send_flow_control(send_flow_control),
    .receive_status(receive_status),
    .message_last(message_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DataW-1:0] rand_data();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[DataW-1:0];
  endfunction

  function automatic frame_t mk_frame(logic [1:0] k, logic [LenW-1:0] len,
                                      logic [SeqW-1:0] sq, logic [DataW-1:0] d);
    frame_t f;
    f.frame_kind = k;
    f.message_length = len;
    f.sequence_number = sq;
    f.data_bytes = d;
    return f;
  endfunction

  function automatic frame_t rand_frame(logic [1:0] k, logic [LenW-1:0] len);
    return mk_frame(k, len, 4'($urandom_range(0, 15)), rand_data());
  endfunction

  function automatic frame_t cons_frame(logic [SeqW-1:0] sq);
    return mk_frame(KIND_CONSEC, 12'($urandom_range(0, 4095)), sq, rand_data());
  endfunction

  task automatic send_frame(input frame_t f);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    frame_kind = f.frame_kind;
    message_length = f.message_length;
    sequence_number = f.sequence_number;
    data_bytes = f.data_bytes;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_frame(f);
    sent++;
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic send_message(input int len);
    int got;
    int pick;
    logic [SeqW-1:0] sq;
    if (len <= 7 && $urandom_range(0, 1) == 1) begin
      send_frame(rand_frame(KIND_SINGLE, 12'(len)));
      return;
    end
    send_frame(rand_frame(KIND_FIRST, 12'(len)));
    got = (len > 6) ? 6 : len;
    sq = '0;
    while (got < len && sent < ITEMS) begin
      sq = sq + 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_frame(rand_frame(KIND_OTHER, 12'($urandom_range(0, 4095))));
        return;
      end else if (pick < 4) begin
        send_frame(cons_frame(sq + 4'($urandom_range(1, 15))));
        return;
      end else if (pick < 6) begin
        return;
      end
      send_frame(cons_frame(sq));
      got += 7;
    end
    if ($urandom_range(0, 19) == 0) send_frame(cons_frame(sq + 1'b1));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result({payload_bytes, payload_count, send_flow_control,
                          receive_status, message_last});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 15);
        repeat (n) begin
          out_stall = 1'b1;
          @(negedge clk);
        end
      end else begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          out_stall = 1'b0;
          @(negedge clk);
        end
      end
    end
  end

  initial begin
    int len_pick;
    int len;
    bit paused;
    board = new();
    quiet = 1'b0;
    sent = 0;
    paused = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    frame_kind = '0;
    message_length = '0;
    sequence_number = '0;
    data_bytes = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_frame(cons_frame(4'd1));
    send_frame(mk_frame(KIND_OTHER, 12'hfff, 4'hf, '1));
    send_frame(mk_frame(KIND_SINGLE, 12'd0, 4'd0, '1));
    send_frame(mk_frame(KIND_SINGLE, 12'd7, 4'hf, '1));
    send_frame(mk_frame(KIND_SINGLE, 12'd8, 4'd0, '1));
    send_frame(mk_frame(KIND_SINGLE, 12'hfff, 4'd0, '0));
    send_frame(rand_frame(KIND_FIRST, 12'd0));
    send_frame(mk_frame(KIND_FIRST, 12'd6, 4'd0, '1));
    send_frame(rand_frame(KIND_FIRST, 12'd7));
    send_frame(mk_frame(KIND_CONSEC, 12'd0, 4'd1, '1));
    send_frame(rand_frame(KIND_FIRST, 12'd20));
    send_frame(cons_frame(4'd1));
    send_frame(cons_frame(4'd3));
    send_frame(cons_frame(4'd4));
    send_frame(rand_frame(KIND_OTHER, 12'd0));
    send_frame(mk_frame(KIND_FIRST, 12'hfff, 4'd0, '1));
    send_frame(cons_frame(4'd1));
    send_frame(rand_frame(KIND_SINGLE, 12'd3));
    send_frame(rand_frame(KIND_FIRST, 12'd13));
    send_frame(cons_frame(4'd1));
    send_frame(cons_frame(4'd2));
    send_frame(rand_frame(KIND_FIRST, 12'd30));
    send_frame(cons_frame(4'd1));
    send_frame(rand_frame(KIND_OTHER, 12'd30));
    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();

    while (sent < ITEMS) begin
      if (sent >= ITEMS - QUIET_TAIL) quiet = 1'b1;
      if (!paused && sent >= ITEMS / 2) begin
        @(negedge clk);
        in_valid = 1'b0;
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 12) begin
        send_frame(rand_frame(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095))));
      end else begin
        len_pick = $urandom_range(0, 99);
        if (len_pick < 55) len = $urandom_range(0, 20);
        else if (len_pick < 85) len = $urandom_range(21, 130);
        else if (len_pick < 97) len = $urandom_range(131, 300);
        else len = $urandom_range(301, 1200);
        send_message(len);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    repeat (5) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
